### sv/dwm_pkg.sv
// ============================================================================
// dwm_pkg
// Shared types and constants of the PWM duty window meter.
// ============================================================================
package dwm_pkg;

    localparam int NUM_LINES_DEF = 16;
    localparam int MAX_REPORT    = 16;
    localparam int DUTY_W        = 8;
    localparam int LINE_W        = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [DUTY_W-1:0] WINDOW_LAST_TICK = 8'd254;
    localparam logic [DUTY_W-1:0] FULL_SCALE       = 8'd255;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_LEVEL = 1'b1
    } t_cmd;

    // One queued report job: lines to report and their duty values.
    typedef struct packed {
        logic [MAX_REPORT-1:0]             mask;
        logic [MAX_REPORT-1:0][DUTY_W-1:0] duty;
    } t_entry;

endpackage

### sv/dwm_if.sv
// ============================================================================
// dwm_in_if / dwm_out_if
// Valid/ready channels for line events and duty reports.
// ============================================================================
interface dwm_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [3:0] line_index;
    logic       level;

    modport source (output valid, cmd, line_index, level, input ready);
    modport sink   (input valid, cmd, line_index, level, output ready);
endinterface

interface dwm_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] line_index_out;
    logic [7:0] duty;
    logic       last;

    modport source (output valid, line_index_out, duty, last, input ready);
    modport sink   (input valid, line_index_out, duty, last, output ready);
endinterface

### sv/dwm_front.sv
// ============================================================================
// dwm_front
// Accepts events, keeps levels, counts and reported values, queues reports.
// ============================================================================
module dwm_front #(
    parameter int NUM_LINES = dwm_pkg::NUM_LINES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dwm_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output dwm_pkg::t_entry o_entry
);
    import dwm_pkg::*;

    localparam int REP = (NUM_LINES < MAX_REPORT) ? NUM_LINES : MAX_REPORT;

    logic [NUM_LINES-1:0]             r_level, n_level;
    logic [NUM_LINES-1:0][DUTY_W-1:0] r_count, n_count;
    logic [NUM_LINES-1:0][DUTY_W-1:0] r_rep,   n_rep;
    logic [DUTY_W-1:0]                r_tick,  n_tick;

    logic [NUM_LINES-1:0][DUTY_W-1:0] v_sum;
    logic [NUM_LINES-1:0]             v_hit;
    logic                             v_acc, v_tick, v_close;

    assign i_in.ready = !i_full;

    always_comb begin
        v_acc   = i_in.valid && !i_full;
        v_tick  = v_acc && (t_cmd'(i_in.cmd) == CMD_TICK);
        v_close = v_tick && (r_tick == WINDOW_LAST_TICK);
        n_level = r_level;
        n_count = r_count;
        n_rep   = r_rep;
        n_tick  = r_tick;
        o_entry = '0;
        o_entry.duty = {MAX_REPORT{FULL_SCALE}};
        for (int i = 0; i < NUM_LINES; i++) begin
            v_sum[i] = r_count[i] + DUTY_W'(r_level[i]);
            v_hit[i] = v_acc && (t_cmd'(i_in.cmd) == CMD_LEVEL)
                       && (int'(i_in.line_index) == i);
            if (v_hit[i]) begin
                n_level[i] = i_in.level;
            end
            if (v_tick) begin
                n_count[i] = v_close ? '0 : v_sum[i];
                if (v_close) begin
                    n_rep[i] = v_sum[i];
                end
            end
        end
        if (v_tick) begin
            n_tick = v_close ? '0 : r_tick + 8'd1;
        end
        for (int j = 0; j < REP; j++) begin
            if (v_close) begin
                o_entry.mask[j] = (r_rep[j] != v_sum[j]);
                o_entry.duty[j] = v_sum[j];
            end else begin
                o_entry.mask[j] = v_hit[j] && i_in.level && (r_rep[j] == '0);
            end
        end
        o_push = (o_entry.mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_count <= '0;
            r_rep   <= '0;
            r_tick  <= '0;
        end else begin
            r_level <= n_level;
            r_count <= n_count;
            r_rep   <= n_rep;
            r_tick  <= n_tick;
        end
    end

endmodule

### sv/dwm_queue.sv
// ============================================================================
// dwm_queue
// Short FIFO of report jobs between front and back.
// ============================================================================
module dwm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dwm_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_full,
    output dwm_pkg::t_entry o_head
);
    import dwm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               v_push, v_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];
    assign v_push  = i_push && !o_full;
    assign v_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (v_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (v_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (v_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(v_push) - CNT_W'(v_pop);
        end
    end

endmodule

### sv/dwm_back.sv
// ============================================================================
// dwm_back
// Drains report jobs one line per cycle into the output register while the output is not stalled.
// ============================================================================
module dwm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  dwm_pkg::t_entry i_head,
    output logic            o_pop,
    dwm_out_if.source       o_out
);
    import dwm_pkg::*;

    logic                              r_act, n_act;
    logic [MAX_REPORT-1:0]             r_mask, n_mask;
    logic [MAX_REPORT-1:0][DUTY_W-1:0] r_duty, n_duty;
    logic                              r_ovalid, n_ovalid;
    logic [LINE_W-1:0]                 r_oline, n_oline;
    logic [DUTY_W-1:0]                 r_oduty, n_oduty;
    logic                              r_olast, n_olast;

    logic [LINE_W-1:0]     v_sel;
    logic [MAX_REPORT-1:0] v_rest;
    logic                  v_emit;

    assign o_out.valid          = r_ovalid;
    assign o_out.line_index_out = r_oline;
    assign o_out.duty           = r_oduty;
    assign o_out.last           = r_olast;

    always_comb begin
        v_sel = '0;
        for (int i = MAX_REPORT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                v_sel = LINE_W'(i);
            end
        end
        v_rest   = r_mask & (r_mask - MAX_REPORT'(1));
        v_emit   = r_act && (!r_ovalid || o_out.ready);
        n_act    = r_act;
        n_mask   = r_mask;
        n_duty   = r_duty;
        n_oline  = r_oline;
        n_oduty  = r_oduty;
        n_olast  = r_olast;
        n_ovalid = o_out.ready ? 1'b0 : r_ovalid;
        if (v_emit) begin
            n_ovalid = 1'b1;
            n_oline  = v_sel;
            n_oduty  = r_duty[v_sel];
            n_olast  = (v_rest == '0);
            n_mask   = v_rest;
            if (v_rest == '0) begin
                n_act = 1'b0;
            end
        end
        o_pop = !i_empty && (!r_act || (v_emit && (v_rest == '0)));
        if (o_pop) begin
            n_act  = 1'b1;
            n_mask = i_head.mask;
            n_duty = i_head.duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
            r_mask   <= '0;
        end else begin
            r_act    <= n_act;
            r_ovalid <= n_ovalid;
            r_mask   <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_duty  <= n_duty;
        r_oline <= n_oline;
        r_oduty <= n_oduty;
        r_olast <= n_olast;
    end

endmodule

### sv/pwm_duty_window_meter.sv
// ============================================================================
// pwm_duty_window_meter
// Duty measurement of bit-banged PWM lines over 255-tick windows.
// ============================================================================
// Input channel i_in: each transaction is a sampling tick (cmd 0) or a level
// change on line line_index (cmd 1). Output channel o_out: duty reports, with
// last set on the final report caused by one input transaction.
// Ticks and level changes update all line state in the cycle they are taken,
// so i_in takes one transaction per cycle while the job queue has room.
// A window close that changes a reported duty, or a first-on rise, places one
// job in a two-entry queue; the back end sends one report per cycle from it
// while o_out is not stalled. A job passes from the queue through the back
// end's job register to the output register.
// When o_out stalls the output register holds; the back end then stops,
// the queue fills and i_in.ready drops, so nothing is lost.
// Reset (synchronous, active low) clears levels, counts, reported values,
// the tick counter, the queue pointers and the output valid flag.
// ============================================================================
module pwm_duty_window_meter #(
    parameter int NUM_LINES = dwm_pkg::NUM_LINES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dwm_in_if.sink    i_in,
    dwm_out_if.source o_out
);
    import dwm_pkg::*;

    logic   w_push, w_pop, w_empty, w_full;
    t_entry w_entry, w_head;

    dwm_front #(
        .NUM_LINES (NUM_LINES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    dwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    dwm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

### tb/dwm_report_checker.sv
// ============================================================================
// dwm_report_checker
// Watches the event and report channels of the PWM duty window meter. It
// keeps its own copy of line levels, high-time counts, reported duties and
// the tick counter, and predicts the duty reports of every accepted event
// transaction. Each accepted report is compared in order against the oldest
// prediction. The mismatch count and the number of outstanding predictions
// go to the top.
// ============================================================================
`timescale 1ns / 1ps

module dwm_report_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dwm_in_if    in_ch,
    dwm_out_if   out_ch,
    output int   o_mismatches,
    output int   o_pending
);
    import dwm_pkg::*;

    localparam int                NUM_LINES    = NUM_LINES_DEF;
    localparam logic [DUTY_W-1:0] WINDOW_TICKS = 8'd255;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [DUTY_W-1:0] duty;
        logic              last;
    } t_report;

    logic [NUM_LINES-1:0] line_high;
    logic [DUTY_W-1:0]    high_cnt   [NUM_LINES];
    logic [DUTY_W-1:0]    shown_duty [NUM_LINES];
    logic [DUTY_W-1:0]    tick_count;
    t_report              pending_reports [$];
    t_report              oldest;

    function automatic void predict_reports(input t_cmd cmd, input logic [LINE_W-1:0] line,
                                            input logic level);
        logic [NUM_LINES-1:0] changed;
        changed = '0;
        if (cmd == CMD_LEVEL) begin
            if (int'(line) < NUM_LINES) begin
                line_high[line] = level;
                if (level && shown_duty[line] == '0)
                    pending_reports.push_back(t_report'{line, FULL_SCALE, 1'b1});
            end
        end else begin
            tick_count = tick_count + 8'd1;
            for (int i = 0; i < NUM_LINES; i++)
                high_cnt[i] = high_cnt[i] + DUTY_W'(line_high[i]);
            if (tick_count == WINDOW_TICKS) begin
                tick_count = '0;
                for (int i = 0; i < NUM_LINES; i++)
                    changed[i] = (shown_duty[i] != high_cnt[i]) && (i < MAX_REPORT);
                for (int i = 0; i < NUM_LINES; i++) begin
                    if (changed[i])
                        pending_reports.push_back(t_report'{LINE_W'(i), high_cnt[i],
                                                    (changed >> (i + 1)) == '0});
                end
                for (int i = 0; i < NUM_LINES; i++) begin
                    shown_duty[i] = high_cnt[i];
                    high_cnt[i]   = '0;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_high    = '0;
            tick_count   = '0;
            o_mismatches = 0;
            for (int i = 0; i < NUM_LINES; i++) begin
                high_cnt[i]   = '0;
                shown_duty[i] = '0;
            end
            pending_reports.delete();
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_reports(t_cmd'(in_ch.cmd), in_ch.line_index, in_ch.level);
            if (out_ch.valid && out_ch.ready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected report: line_index_out %0d duty %0d last %0b",
                           out_ch.line_index_out, out_ch.duty, out_ch.last);
                    o_mismatches++;
                end else begin
                    oldest = pending_reports.pop_front();
                    if (out_ch.line_index_out !== oldest.line) begin
                        $error("line_index_out: expected %0d, actual %0d",
                               oldest.line, out_ch.line_index_out);
                        o_mismatches++;
                    end
                    if (out_ch.duty !== oldest.duty) begin
                        $error("duty: expected %0d, actual %0d", oldest.duty, out_ch.duty);
                        o_mismatches++;
                    end
                    if (out_ch.last !== oldest.last) begin
                        $error("last: expected %0b, actual %0b", oldest.last, out_ch.last);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = pending_reports.size();
    end

endmodule

### tb/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the PWM duty window meter. A short directed run
// covers first-on reports on the edge lines, repeated and falling levels and
// ticks with arbitrary payload. Random phases then mix ticks and level
// changes so that a window closes, with sender idling and receiver stalls
// varied per phase and one long receiver hold-off that backs up the input
// channel. The checker module does all prediction and comparison.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import dwm_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int idle_pct  = 0;
    int stall_pct = 0;
    int tick_pct  = 80;
    int ticks_sent = 0;
    bit hold_req  = 1'b0;
    int mismatches;
    int pending;

    int idle_by_phase  [4] = '{0, 85, 0, 30};
    int stall_by_phase [4] = '{0, 0, 85, 30};
    int tick_by_phase  [4] = '{40, 95, 95, 95};
    int items_by_phase [4] = '{40, 90, 90, 90};

    dwm_in_if  in_ch ();
    dwm_out_if out_ch ();

    pwm_duty_window_meter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dwm_report_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    task automatic send_event(input t_cmd cmd, input logic [LINE_W-1:0] line,
                              input logic level);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.line_index <= line;
        in_ch.level      <= level;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (cmd == CMD_TICK)
            ticks_sent++;
    endtask

    task automatic send_random();
        logic [LINE_W-1:0] line;
        // keep lines 0 and 15 untouched through the first window
        if (ticks_sent < 255)
            line = LINE_W'($urandom_range(14, 1));
        else
            line = LINE_W'($urandom_range(15));
        if ($urandom_range(99) < tick_pct)
            send_event(CMD_TICK, LINE_W'($urandom_range(15)), 1'($urandom_range(1)));
        else
            send_event(CMD_LEVEL, line, 1'($urandom_range(1)));
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_TICK;
        in_ch.line_index <= '0;
        in_ch.level      <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_event(CMD_LEVEL, 4'd0, 1'b1);
        send_event(CMD_LEVEL, 4'd15, 1'b1);
        send_event(CMD_LEVEL, 4'd15, 1'b1);
        send_event(CMD_LEVEL, 4'd15, 1'b0);
        send_event(CMD_LEVEL, 4'd15, 1'b1);
        send_event(CMD_LEVEL, 4'd0, 1'b0);
        send_event(CMD_LEVEL, 4'd0, 1'b0);
        send_event(CMD_LEVEL, 4'd7, 1'b1);
        send_event(CMD_LEVEL, 4'd7, 1'b0);
        send_event(CMD_TICK, 4'd15, 1'b1);
        send_event(CMD_TICK, 4'd0, 1'b0);
        send_event(CMD_TICK, 4'd10, 1'b1);
        send_event(CMD_LEVEL, 4'd5, 1'b1);
        send_event(CMD_LEVEL, 4'd10, 1'b1);
        send_event(CMD_LEVEL, 4'd3, 1'b1);
        send_event(CMD_TICK, 4'd5, 1'b0);
        send_event(CMD_LEVEL, 4'd10, 1'b0);
        send_event(CMD_TICK, 4'd3, 1'b1);
        send_event(CMD_LEVEL, 4'd8, 1'b0);
        send_event(CMD_TICK, 4'd12, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            tick_pct  = tick_by_phase[ph];
            if (ph == 0)
                hold_req = 1'b1;
            for (int n = 0; n < items_by_phase[ph]; n++)
                send_random();
        end

        in_ch.valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending != 0)
            $error("%0d expected reports never arrived", pending);
        if (mismatches == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
sv/dwm_pkg.sv
sv/dwm_if.sv
sv/dwm_front.sv
sv/dwm_queue.sv
sv/dwm_back.sv
sv/pwm_duty_window_meter.sv
tb/dwm_report_checker.sv
tb/testbench.sv
